// File: rtl/evi_pkg.sv
package evi_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int ELAPSED_W   = 32;
  localparam int DUR_W       = 24;
  localparam int MODE_W      = 3;

  // quotient bits resolved per divider stage
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES         = FRAC_BITS / DIV_BITS_PER_STAGE;

  // signed working width of the easing datapath (covers -4 up to just under +4 in Q.F)
  localparam int X_W = FRAC_BITS + 3;

  localparam logic [X_W-1:0] ONE_Q = X_W'(64'd1 << FRAC_BITS);
  localparam logic [X_W-1:0] BACK_C1 =
    X_W'((64'd170158 * (64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000);
  localparam logic [X_W-1:0] BACK_C3 =
    X_W'((64'd270158 * (64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000);

  typedef enum logic [MODE_W-1:0] {
    EASE_LINEAR       = 3'd0,
    EASE_OUT_QUAD     = 3'd1,
    EASE_IN_OUT_CUBIC = 3'd2,
    EASE_OUT_CUBIC    = 3'd3,
    EASE_IN_CUBIC     = 3'd4,
    EASE_OUT_BACK     = 3'd5,
    EASE_IN_BACK      = 3'd6,
    EASE_LINEAR_ALT   = 3'd7
  } ease_mode_t;

  // fields that ride along with an item through the pipe
  typedef struct packed {
    ease_mode_t                    mode;
    logic signed [VALUE_WIDTH-1:0] origin;
    logic signed [VALUE_WIDTH-1:0] target;
    logic                          finished;
  } evi_side_t;

endpackage

// File: rtl/evi_div.sv
module evi_div
  import evi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [ELAPSED_W-1:0] elapsed,
  input  logic [DUR_W-1:0]     duration,
  input  evi_side_t            in_side,
  output logic                 t_valid,
  output logic [FRAC_BITS:0]   t,
  output evi_side_t            t_side
);

  logic                 vld_r  [DIV_STAGES];
  logic [DUR_W-1:0]     rem_r  [DIV_STAGES];
  logic [DUR_W-1:0]     den_r  [DIV_STAGES];
  logic [FRAC_BITS-1:0] quo_r  [DIV_STAGES];
  evi_side_t            side_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic                 vin;
    logic [DUR_W-1:0]     rin;
    logic [DUR_W-1:0]     din;
    logic [FRAC_BITS-1:0] qin;
    evi_side_t            sin;
    logic [DUR_W-1:0]     rem_nxt;
    logic [FRAC_BITS-1:0] quo_nxt;

    if (s == 0) begin : g_first
      // elapsed < duration whenever not finished, so it fits the remainder
      assign vin = in_valid;
      assign rin = in_side.finished ? '0 : elapsed[DUR_W-1:0];
      assign din = duration;
      assign qin = '0;
      assign sin = in_side;
    end else begin : g_next
      assign vin = vld_r[s-1];
      assign rin = rem_r[s-1];
      assign din = den_r[s-1];
      assign qin = quo_r[s-1];
      assign sin = side_r[s-1];
    end

    // restoring division, two quotient bits per stage
    always_comb begin
      logic [DUR_W:0]       r;
      logic [FRAC_BITS-1:0] q;
      r = {1'b0, rin};
      q = qin;
      for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
        r = {r[DUR_W-1:0], 1'b0};
        if (r >= {1'b0, din}) begin
          r = r - {1'b0, din};
          q = {q[FRAC_BITS-2:0], 1'b1};
        end else begin
          q = {q[FRAC_BITS-2:0], 1'b0};
        end
      end
      rem_nxt = r[DUR_W-1:0];
      quo_nxt = q;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        den_r[s]  <= din;
        quo_r[s]  <= quo_nxt;
        side_r[s] <= sin;
      end
    end
  end

  assign t_valid = vld_r[DIV_STAGES-1];
  assign t_side  = side_r[DIV_STAGES-1];
  assign t = side_r[DIV_STAGES-1].finished ? ONE_Q[FRAC_BITS:0]
                                          : {1'b0, quo_r[DIV_STAGES-1]};

`ifndef NO_ASSERTIONS
  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    t_valid |-> t <= ONE_Q[FRAC_BITS:0])
    else $error("progress above one");
`endif

endmodule

// File: rtl/evi_ease.sv
module evi_ease
  import evi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  t_valid,
  input  logic [FRAC_BITS:0]    t,
  input  evi_side_t             t_side,
  output logic                  e_valid,
  output logic signed [X_W-1:0] e,
  output evi_side_t             e_side
);

  localparam int P_W = 2 * X_W;

  logic signed [X_W-1:0] tq;
  logic signed [X_W-1:0] a_nxt, b_nxt;
  logic signed [P_W-1:0] prod1, prod2, prod3, prod1c;
  logic signed [X_W-1:0] e_nxt;

  // stage 1
  logic                  v1_r;
  logic signed [X_W-1:0] p1_r, x1_r, t1_r;
  logic                  lo1_r;
  evi_side_t             s1_r;
  // stage 2
  logic                  v2_r;
  logic signed [X_W-1:0] p2_r, c2_r, t2_r;
  logic                  lo2_r;
  evi_side_t             s2_r;
  // stage 3
  logic                  v3_r;
  logic signed [X_W-1:0] p3_r, c3_r, t3_r, m1_r, m3_r;
  logic                  lo3_r;
  evi_side_t             s3_r;
  // stage 4
  logic                  v4_r;
  logic signed [X_W-1:0] e4_r;
  evi_side_t             s4_r;

  assign tq = $signed({{(X_W-FRAC_BITS-1){1'b0}}, t});

  // operand select for the first product
  always_comb begin
    a_nxt = tq;
    b_nxt = tq;
    case (t_side.mode)
      EASE_OUT_QUAD: begin
        b_nxt = (ONE_Q <<< 1) - tq;
      end
      EASE_IN_OUT_CUBIC: begin
        if (tq >= (ONE_Q >>> 1)) begin
          a_nxt = (tq <<< 1) - (ONE_Q <<< 1);
          b_nxt = a_nxt;
        end
      end
      EASE_OUT_CUBIC, EASE_OUT_BACK: begin
        a_nxt = tq - ONE_Q;
        b_nxt = a_nxt;
      end
      default: begin
        a_nxt = tq;
        b_nxt = tq;
      end
    endcase
  end

  assign prod1  = (P_W'(a_nxt) * P_W'(b_nxt)) >>> FRAC_BITS;
  assign prod2  = (P_W'(p1_r) * P_W'(x1_r)) >>> FRAC_BITS;
  assign prod3  = (P_W'($signed(BACK_C3)) * P_W'(c2_r)) >>> FRAC_BITS;
  assign prod1c = (P_W'($signed(BACK_C1)) * P_W'(p2_r)) >>> FRAC_BITS;

  // upper half of in-out-cubic needs a signed floor halving of a negative cube
  always_comb begin
    case (s3_r.mode)
      EASE_OUT_QUAD:     e_nxt = p3_r;
      EASE_IN_OUT_CUBIC: e_nxt = lo3_r ? (c3_r <<< 2) : ((c3_r >>> 1) + $signed(ONE_Q));
      EASE_OUT_CUBIC:    e_nxt = c3_r + ONE_Q;
      EASE_IN_CUBIC:     e_nxt = c3_r;
      EASE_OUT_BACK:     e_nxt = ONE_Q + m3_r + m1_r;
      EASE_IN_BACK:      e_nxt = m3_r - m1_r;
      default:           e_nxt = t3_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= t_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= prod1[X_W-1:0];
      x1_r  <= a_nxt;
      t1_r  <= tq;
      lo1_r <= (tq < (ONE_Q >>> 1));
      s1_r  <= t_side;

      p2_r  <= p1_r;
      c2_r  <= prod2[X_W-1:0];
      t2_r  <= t1_r;
      lo2_r <= lo1_r;
      s2_r  <= s1_r;

      p3_r  <= p2_r;
      c3_r  <= c2_r;
      m3_r  <= prod3[X_W-1:0];
      m1_r  <= prod1c[X_W-1:0];
      t3_r  <= t2_r;
      lo3_r <= lo2_r;
      s3_r  <= s2_r;

      e4_r  <= e_nxt;
      s4_r  <= s3_r;
    end
  end

  assign e_valid = v4_r;
  assign e       = e4_r;
  assign e_side  = s4_r;

`ifndef NO_ASSERTIONS
  a_e_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    e_valid |-> (e > -$signed(ONE_Q >>> 1)) && (e < $signed(ONE_Q <<< 1)))
    else $error("eased weight out of range");
  a_lin_pass: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && (s3_r.mode == EASE_LINEAR || s3_r.mode == EASE_LINEAR_ALT) && en
    |=> e4_r == $past(t3_r))
    else $error("linear weight differs from progress");
`endif

endmodule

// File: rtl/evi_blend.sv
module evi_blend
  import evi_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          e_valid,
  input  logic signed [X_W-1:0]         e,
  input  evi_side_t                     e_side,
  output logic                          out_valid,
  output logic signed [VALUE_WIDTH-1:0] value,
  output logic                          finished
);

  localparam int D_W   = VALUE_WIDTH + 1;
  localparam int DH_W  = D_W - FRAC_BITS;
  localparam int M_W   = DH_W + X_W + 1;
  localparam int SUM_W = M_W + 2;
  localparam logic signed [SUM_W-1:0] VMAX = SUM_W'((64'd1 << (VALUE_WIDTH-1)) - 64'd1);
  localparam logic signed [SUM_W-1:0] VMIN = -VMAX - SUM_W'(1);

  logic signed [D_W-1:0]   diff;
  logic signed [DH_W-1:0]  dh;
  logic signed [FRAC_BITS:0] dl;
  logic signed [SUM_W-1:0] sum;

  logic                          v1_r;
  logic signed [M_W-1:0]         hi_r, lo_r;
  logic signed [VALUE_WIDTH-1:0] st_r;
  logic                          fin1_r;

  logic                          v2_r;
  logic signed [VALUE_WIDTH-1:0] val_r;
  logic                          fin2_r;

  // diff*e split into high and low parts so both products stay narrow
  assign diff = D_W'(e_side.target) - D_W'(e_side.origin);
  assign dh   = DH_W'(diff >>> FRAC_BITS);
  assign dl   = $signed({1'b0, diff[FRAC_BITS-1:0]});

  assign sum = SUM_W'(st_r) + SUM_W'(hi_r) + SUM_W'(lo_r >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= e_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi_r   <= M_W'(dh) * M_W'(e);
      lo_r   <= M_W'(dl) * M_W'(e);
      st_r   <= e_side.origin;
      fin1_r <= e_side.finished;
      if (sum > VMAX) begin
        val_r <= VMAX[VALUE_WIDTH-1:0];
      end else if (sum < VMIN) begin
        val_r <= VMIN[VALUE_WIDTH-1:0];
      end else begin
        val_r <= sum[VALUE_WIDTH-1:0];
      end
      fin2_r <= fin1_r;
    end
  end

  assign out_valid = v2_r;
  assign value     = val_r;
  assign finished  = fin2_r;

endmodule

// File: rtl/eased_value_interpolator_unit.sv
// Pipeline: 8 divider stages, 4 easing stages and 2 blend stages from input
// request to result.
// Throughput: one request per cycle; the whole pipe holds while the result
// register is full and not taken, so in_tready = !out_tvalid | out_tready.
// Reset: rst_n synchronous, active low; clears only the stage valid bits.
module eased_value_interpolator_unit
  import evi_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] elapsed time, [55:32] duration, [58:56] easing mode,
  // [90:59] start value, [122:91] end value, [127:123] zero
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] value
  output logic [31:0]  out_tdata,
  // finished: progress reached one
  output logic         out_tlast
);

  logic                 en;
  logic [ELAPSED_W-1:0] elapsed;
  logic [DUR_W-1:0]     duration;
  evi_side_t            in_side;

  logic                          t_valid;
  logic [FRAC_BITS:0]            t;
  evi_side_t                     t_side;
  logic                          e_valid;
  logic signed [X_W-1:0]         e;
  evi_side_t                     e_side;
  logic signed [VALUE_WIDTH-1:0] value;

  // single pipe-wide advance; the result register splits the two sides
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  assign elapsed  = in_tdata[31:0];
  assign duration = in_tdata[55:32];

  always_comb begin
    in_side.mode     = ease_mode_t'(in_tdata[58:56]);
    in_side.origin   = $signed(in_tdata[90:59]);
    in_side.target   = $signed(in_tdata[122:91]);
    // zero duration also lands here
    in_side.finished = ({8'd0, duration} <= elapsed);
  end

  // progress t = elapsed / duration in Q1.F, pinned to one when finished
  evi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .elapsed  (elapsed),
    .duration (duration),
    .in_side  (in_side),
    .t_valid  (t_valid),
    .t        (t),
    .t_side   (t_side)
  );

  // easing curve: square, cube, back terms, combine
  evi_ease u_ease (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .t_valid (t_valid),
    .t       (t),
    .t_side  (t_side),
    .e_valid (e_valid),
    .e       (e),
    .e_side  (e_side)
  );

  // start + floor((end-start)*e >> F), saturated
  evi_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .e_valid   (e_valid),
    .e         (e),
    .e_side    (e_side),
    .out_valid (out_tvalid),
    .value     (value),
    .finished  (out_tlast)
  );

  assign out_tdata = value;

`ifndef NO_ASSERTIONS
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("ready does not follow result register");
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(e) && $stable(e_valid))
    else $error("pipe moved while stalled");
`endif

endmodule

// File: dv/eased_value_interpolator_unit_tb.sv
module eased_value_interpolator_unit_tb
  import evi_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int N_RANDOM    = 830;
  localparam int DRAIN_WAIT  = 40;   // margin past the full pipe depth

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [31:0]  out_tdata;
  logic         out_tlast;

  // one queued expectation per accepted request
  typedef struct {
    logic [31:0] value;
    logic        finished;
  } eased_result_t;

  // directed rows; check_typed marks rows whose answer is written out here
  typedef struct {
    logic [31:0] elapsed;
    logic [23:0] duration;
    ease_mode_t  mode;
    logic [31:0] start_v;
    logic [31:0] end_v;
    bit          check_typed;
    logic [31:0] typed_value;
    logic        typed_fin;
  } sample_row_t;

  eased_result_t pending_results[$];
  sample_row_t   sample_rows[$];
  int            mismatch_cnt;
  int unsigned   cycle_cnt;
  bit            burst_in;
  bit            burst_out;

  eased_value_interpolator_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void add_row(sample_row_t r);
    sample_rows = {sample_rows, r};
  endfunction

  // Q16 product, floored (arithmetic shift)
  function automatic longint q16_mul(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  // easing weight for progress t (Q1.16, 0..ONE)
  function automatic longint ease_weight(ease_mode_t mode, longint t);
    longint one_q;
    longint c1;
    longint c3;
    longint f;
    longint f2;
    longint f3;
    one_q = longint'(1) << FRAC_BITS;
    c1 = 111515;
    c3 = 177051;
    case (mode)
      EASE_OUT_QUAD: begin
        return q16_mul(t, 2 * one_q - t);
      end
      EASE_IN_OUT_CUBIC: begin
        if (t < one_q / 2) return 4 * q16_mul(q16_mul(t, t), t);
        f = 2 * t - 2 * one_q;
        f3 = q16_mul(q16_mul(f, f), f);
        return (f3 >>> 1) + one_q;
      end
      EASE_OUT_CUBIC: begin
        f = t - one_q;
        return q16_mul(q16_mul(f, f), f) + one_q;
      end
      EASE_IN_CUBIC: begin
        return q16_mul(q16_mul(t, t), t);
      end
      EASE_OUT_BACK: begin
        f = t - one_q;
        f2 = q16_mul(f, f);
        f3 = q16_mul(f2, f);
        return one_q + q16_mul(c3, f3) + q16_mul(c1, f2);
      end
      EASE_IN_BACK: begin
        f2 = q16_mul(t, t);
        f3 = q16_mul(f2, t);
        return q16_mul(c3, f3) - q16_mul(c1, f2);
      end
      default: begin
        return t;
      end
    endcase
  endfunction

  function automatic eased_result_t eased_sample(logic [31:0] elapsed, logic [23:0] duration,
                                                 ease_mode_t mode, logic [31:0] start_v,
                                                 logic [31:0] end_v);
    eased_result_t r;
    longint t;
    longint e;
    longint s;
    longint d;
    longint diff;
    longint dh;
    longint dl;
    longint v;
    longint unsigned num;
    r.finished = (elapsed >= 32'(duration));
    if (r.finished) begin
      t = longint'(1) << FRAC_BITS;
    end else begin
      num = longint'(elapsed) << FRAC_BITS;
      t = longint'(num / longint'(duration));
    end
    e = ease_weight(mode, t);
    s = longint'($signed(start_v));
    d = longint'($signed(end_v));
    diff = d - s;
    dh = diff >>> FRAC_BITS;
    dl = diff - (dh <<< FRAC_BITS);
    v = s + dh * e + ((dl * e) >>> FRAC_BITS);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    r.value = v[31:0];
    return r;
  endfunction

  function automatic sample_row_t random_row();
    sample_row_t r;
    int sel;
    r.check_typed = 1'b0;
    r.typed_value = '0;
    r.typed_fin = 1'b0;
    r.mode = ease_mode_t'($urandom_range(0, 7));
    sel = $urandom_range(0, 9);
    // mostly sane animations, some raw noise, zero durations and near-end elapsed
    if (sel < 6) begin
      r.duration = 24'($urandom_range(1, 5000));
      r.elapsed = $urandom_range(0, 32'(r.duration) + 32'(r.duration) / 5);
    end else if (sel < 8) begin
      r.duration = 24'($urandom);
      r.elapsed = ($urandom_range(0, 1)) ? ($urandom & 32'h00ff_ffff) : $urandom;
    end else if (sel == 8) begin
      r.duration = '0;
      r.elapsed = $urandom;
    end else begin
      r.duration = 24'($urandom);
      r.elapsed = 32'(r.duration) - $urandom_range(0, 3);
    end
    if ($urandom_range(0, 2) == 0) begin
      r.start_v = $urandom;
      r.end_v = $urandom;
    end else begin
      r.start_v = 32'($signed($urandom_range(0, 20000)) - 10000);
      r.end_v = 32'($signed($urandom_range(0, 20000)) - 10000);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random stalls, compare against oldest expectation
  initial begin : result_side
    int stall;
    bit seen;
    logic [31:0] got_value;
    logic got_fin;
    eased_result_t want;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) burst_out = ~burst_out;
      stall = burst_out ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(negedge clk);
        seen = out_tvalid;
        got_value = out_tdata;
        got_fin = out_tlast;
        @(posedge clk);
      end while (!seen);
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result value=%h fin=%b",
                                         got_value, got_fin);
      end else begin
        want = pending_results.pop_front();
        if (got_value !== want.value || got_fin !== want.finished) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result mismatch: exp value=%h fin=%b, got value=%h fin=%b",
                     want.value, want.finished, got_value, got_fin);
        end
      end
    end
  end

  // request side
  initial begin : request_side
    sample_row_t row;
    eased_result_t want;
    int gap;
    bit took;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    mismatch_cnt = 0;
    cycle_cnt = 0;
    burst_in = 1'b0;
    burst_out = 1'b0;

    // directed: every mode finished lands exactly on end_v; one unfinished row stays on start_v
    add_row('{32'd0, 24'd0, EASE_LINEAR, 32'hffff_fffb, 32'd77, 1, 32'd77, 1});
    add_row('{32'd0, 24'd100, EASE_LINEAR, 32'd123, 32'd999, 1, 32'd123, 0});
    add_row('{32'hffff_ffff, 24'd1, EASE_OUT_QUAD, 32'd5, 32'd9, 1, 32'd9, 1});
    add_row('{32'd500, 24'd500, EASE_IN_OUT_CUBIC, 32'h8000_0000, 32'h7fff_ffff,
              1, 32'h7fff_ffff, 1});
    add_row('{32'd7, 24'd3, EASE_OUT_CUBIC, 32'h7fff_ffff, 32'h8000_0000,
              1, 32'h8000_0000, 1});
    add_row('{32'd9, 24'd0, EASE_IN_CUBIC, 32'd0, 32'hffff_ffff, 1, 32'hffff_ffff, 1});
    add_row('{32'd20, 24'd20, EASE_OUT_BACK, 32'd1, 32'd2, 1, 32'd2, 1});
    add_row('{32'd21, 24'd20, EASE_IN_BACK, 32'd3, 32'd4, 1, 32'd4, 1});
    add_row('{32'd1, 24'd0, EASE_LINEAR_ALT, 32'd10, 32'd11, 1, 32'd11, 1});
    // predictor rows: midpoints, back overshoot into saturation, widest fields
    add_row('{32'd50, 24'd100, EASE_LINEAR, 32'd0, 32'd1000, 0, 0, 0});
    add_row('{32'd49, 24'd100, EASE_IN_OUT_CUBIC, 32'd0, 32'd100000, 0, 0, 0});
    add_row('{32'd51, 24'd100, EASE_IN_OUT_CUBIC, 32'd0, 32'd100000, 0, 0, 0});
    add_row('{32'd50, 24'd100, EASE_IN_OUT_CUBIC, 32'hffff_0000, 32'd7, 0, 0, 0});
    add_row('{32'd70, 24'd100, EASE_OUT_BACK, 32'h8000_0000, 32'h7fff_ffff,
              0, 0, 0});
    add_row('{32'd20, 24'd100, EASE_IN_BACK, 32'h8000_0000, 32'h7fff_ffff,
              0, 0, 0});
    add_row('{32'd20, 24'd100, EASE_IN_BACK, 32'h7fff_ffff, 32'h8000_0000,
              0, 0, 0});
    add_row('{32'hffff_fffe, 24'hff_ffff, EASE_OUT_QUAD, 32'hffff_ffff,
              32'h0000_0001, 0, 0, 0});
    add_row('{32'h00ff_fffe, 24'hff_ffff, EASE_OUT_CUBIC, 32'h1234_5678,
              32'hedcb_a987, 0, 0, 0});
    add_row('{32'd1, 24'hff_ffff, EASE_IN_CUBIC, 32'h8000_0000, 32'h7fff_ffff,
              0, 0, 0});
    add_row('{32'd3, 24'd7, EASE_LINEAR_ALT, 32'h5555_5555, 32'haaaa_aaaa,
              0, 0, 0});
    for (int i = 0; i < N_RANDOM; i++) add_row(random_row());

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (sample_rows[i]) begin
      row = sample_rows[i];
      // hold off once until the pipe has fully drained
      if (i == 400) begin
        in_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 63) == 0) burst_in = ~burst_in;
      gap = burst_in ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata <= {5'b0, row.end_v, row.start_v, row.mode, row.duration, row.elapsed};
      if (row.check_typed) begin
        want.value = row.typed_value;
        want.finished = row.typed_fin;
      end else begin
        want = eased_sample(row.elapsed, row.duration, row.mode, row.start_v, row.end_v);
      end
      do begin
        @(negedge clk);
        took = in_tready;
        @(posedge clk);
      end while (!took);
      pending_results = {pending_results, want};
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
